### src/assert_macros.svh
// Assertion macros used by the queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/fqs_pkg.sv
package fqs_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int DATA_W          = 32;
	localparam int COUNT_W         = 5;

	typedef logic [1:0] op_t;
	typedef logic [1:0] err_t;

	localparam op_t OP_INSERT = 2'd0;
	localparam op_t OP_DELETE = 2'd1;
	localparam op_t OP_SEARCH = 2'd2;

	localparam err_t ERR_OK    = 2'd0;
	localparam err_t ERR_EMPTY = 2'd1;
	localparam err_t ERR_FULL  = 2'd2;

endpackage

### src/fifo_queue_with_search.sv
// Queue of signed 32-bit items in a ring store, with insert, delete and linear search.
// An insert, an error or the unused code goes from idle to the done state; a delete passes
// through the pop state and a search through the scan state before the done state.
// Search rate is one entry a cycle, set by the single read port of the store.
// A new operation is taken only in the idle state, once the last result is in the output register.
// Reset clears pointers, count and handshake state at once; store contents are undefined.
module fifo_queue_with_search #(
	parameter int QUEUE_DEPTH = fqs_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               item_valid,
	output logic                               item_ready,
	input  fqs_pkg::op_t                       operation,
	input  logic signed [fqs_pkg::DATA_W-1:0]  item_value,
	output logic                               result_valid,
	input  logic                               result_ready,
	output logic signed [fqs_pkg::DATA_W-1:0]  removed_value,
	output logic                               found,
	output fqs_pkg::err_t                      error_code,
	output logic [fqs_pkg::COUNT_W-1:0]        entry_count
);
	import fqs_pkg::*;

	`include "assert_macros.svh"

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);
	localparam logic [AW-1:0] LAST_POS = AW'(QUEUE_DEPTH - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_POP,
		ST_SCAN,
		ST_DONE
	} state_t;

	state_t                state_q;
	logic [AW-1:0]         head_q;
	logic [AW-1:0]         tail_q;
	logic [CW-1:0]         count_q;
	logic [AW-1:0]         pos_q;
	logic [CW-1:0]         issued_q;
	logic                  rd_pending_q;
	logic signed [DATA_W-1:0] val_q;
	logic signed [DATA_W-1:0] res_removed_q;
	logic                  res_found_q;
	err_t                  res_err_q;
	logic                  result_valid_q;
	logic signed [DATA_W-1:0] removed_value_q;
	logic                  found_q;
	err_t                  error_code_q;
	logic [COUNT_W-1:0]    entry_count_q;

	logic                  accept;
	logic                  is_full;
	logic                  is_empty;
	logic                  full_insert;
	logic                  hit;
	logic                  scan_issue;
	logic                  wr_en;
	logic                  rd_en;
	logic [AW-1:0]         rd_addr;
	logic signed [DATA_W-1:0] rd_data;

	function automatic logic [AW-1:0] next_pos(input logic [AW-1:0] pos);
		return (pos == LAST_POS) ? '0 : pos + AW'(1);
	endfunction

	assign item_ready  = (state_q == ST_IDLE);
	assign accept      = item_valid && item_ready;
	assign is_full     = (count_q == FULL_CNT);
	assign is_empty    = (count_q == '0);
	assign full_insert = accept && (operation == OP_INSERT) && is_full;

	// Read data registered last cycle belongs to the entry issued then.
	assign hit        = rd_pending_q && (rd_data == val_q);
	assign scan_issue = (state_q == ST_SCAN) && !hit && (issued_q != count_q);

	assign wr_en   = accept && (operation == OP_INSERT) && !is_full;
	assign rd_en   = (accept && (operation == OP_DELETE) && !is_empty) || scan_issue;
	assign rd_addr = (state_q == ST_SCAN) ? pos_q : head_q;

	fqs_store #(
		.DEPTH (QUEUE_DEPTH),
		.AW    (AW)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (tail_q),
		.wr_data (item_value),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			head_q         <= '0;
			tail_q         <= '0;
			count_q        <= '0;
			pos_q          <= '0;
			issued_q       <= '0;
			rd_pending_q   <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			// In the done state the output register is reloaded instead.
			if (result_valid_q && result_ready && (state_q != ST_DONE)) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						val_q         <= item_value;
						res_removed_q <= '0;
						res_found_q   <= 1'b0;
						res_err_q     <= ERR_OK;
						rd_pending_q  <= 1'b0;
						issued_q      <= '0;
						pos_q         <= head_q;
						state_q       <= ST_DONE;
						case (operation)
							OP_INSERT: begin
								if (is_full) begin
									res_err_q <= ERR_FULL;
								end else begin
									tail_q  <= next_pos(tail_q);
									count_q <= count_q + CW'(1);
								end
							end
							OP_DELETE: begin
								if (is_empty) begin
									res_err_q <= ERR_EMPTY;
								end else begin
									state_q <= ST_POP;
								end
							end
							OP_SEARCH: begin
								if (is_empty) begin
									res_err_q <= ERR_EMPTY;
								end else begin
									state_q <= ST_SCAN;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_POP: begin
					res_removed_q <= rd_data;
					head_q        <= next_pos(head_q);
					count_q       <= count_q - CW'(1);
					state_q       <= ST_DONE;
				end
				ST_SCAN: begin
					if (hit) begin
						res_found_q <= 1'b1;
						state_q     <= ST_DONE;
					end else if (issued_q == count_q) begin
						// The last held entry was compared in this cycle without a match.
						state_q <= ST_DONE;
					end else begin
						pos_q        <= next_pos(pos_q);
						issued_q     <= issued_q + CW'(1);
						rd_pending_q <= 1'b1;
					end
				end
				ST_DONE: begin
					if (!result_valid_q || result_ready) begin
						removed_value_q <= res_removed_q;
						found_q         <= res_found_q;
						error_code_q    <= res_err_q;
						entry_count_q   <= COUNT_W'(count_q);
						result_valid_q  <= 1'b1;
						state_q         <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result_valid  = result_valid_q;
	assign removed_value = removed_value_q;
	assign found         = found_q;
	assign error_code    = error_code_q;
	assign entry_count   = entry_count_q;

	`ASSERT_SAME(a_count_bound, 1'b1, count_q <= FULL_CNT, "held count above queue depth")
	`ASSERT_NEXT(a_full_drop, full_insert, $stable({count_q, tail_q}), "full insert changed state")
	`ASSERT_SAME(a_scan_issue, state_q == ST_SCAN, (issued_q <= count_q) && !wr_en, "scan overran")

endmodule

### src/fqs_store.sv
module fqs_store #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic                               clk,
	input  logic                               wr_en,
	input  logic [AW-1:0]                      wr_addr,
	input  logic signed [fqs_pkg::DATA_W-1:0]  wr_data,
	input  logic                               rd_en,
	input  logic [AW-1:0]                      rd_addr,
	output logic signed [fqs_pkg::DATA_W-1:0]  rd_data
);
	import fqs_pkg::*;

	logic signed [DATA_W-1:0] mem [DEPTH];
	logic signed [DATA_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### bench/tb_fifo_queue_with_search.sv
module tb_fifo_queue_with_search;
	import fqs_pkg::*;

	localparam int DEPTH = QUEUE_DEPTH_DEF;
	// The block leaves the queue unchanged for the fourth operation code but still gives a result.
	localparam op_t OP_UNUSED = 2'd3;
	localparam int HOLD_CYCLES = 300;
	localparam int STALL_LIMIT = 2000;
	localparam int RANDOM_ITEMS = 930;

	typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} op_mix_t;

	typedef struct {
		logic signed [DATA_W-1:0] removed_value;
		logic                     found;
		err_t                     error_code;
		logic [COUNT_W-1:0]       entry_count;
	} queue_result_t;

	class queue_scoreboard;
		logic signed [DATA_W-1:0] mirror_store [DEPTH];
		int head_pos = 0;
		int tail_pos = 0;
		int held = 0;
		queue_result_t awaited_results [$];
		int mismatches = 0;
		int results_seen = 0;
		int full_refusals = 0;
		int empty_refusals = 0;
		int search_hits = 0;

		function queue_result_t predict_queue_op(op_t op, logic signed [DATA_W-1:0] value);
			queue_result_t r;
			int pos;
			r.removed_value = '0;
			r.found = 1'b0;
			r.error_code = ERR_OK;
			case (op)
				OP_INSERT: begin
					if (held >= DEPTH) begin
						r.error_code = ERR_FULL;
						full_refusals++;
					end else begin
						mirror_store[tail_pos] = value;
						tail_pos = (tail_pos + 1) % DEPTH;
						held++;
					end
				end
				OP_DELETE: begin
					if (held == 0) begin
						r.error_code = ERR_EMPTY;
						empty_refusals++;
					end else begin
						r.removed_value = mirror_store[head_pos];
						head_pos = (head_pos + 1) % DEPTH;
						held--;
					end
				end
				OP_SEARCH: begin
					if (held == 0) begin
						r.error_code = ERR_EMPTY;
						empty_refusals++;
					end else begin
						pos = head_pos;
						for (int k = 0; k < held; k++) begin
							if (mirror_store[pos] == value)
								r.found = 1'b1;
							pos = (pos + 1) % DEPTH;
						end
						if (r.found)
							search_hits++;
					end
				end
				default: ;
			endcase
			r.entry_count = COUNT_W'(held);
			return r;
		endfunction

		function void note_transfer(op_t op, logic signed [DATA_W-1:0] value);
			awaited_results.push_back(predict_queue_op(op, value));
		endfunction

		function void check_result(logic signed [DATA_W-1:0] removed_value, logic found,
				err_t error_code, logic [COUNT_W-1:0] entry_count);
			queue_result_t e;
			results_seen++;
			if (awaited_results.size() == 0) begin
				$error("result transfer with no operation outstanding");
				mismatches++;
				return;
			end
			e = awaited_results.pop_front();
			if (removed_value !== e.removed_value) begin
				$error("removed_value: expected %0d, got %0d", e.removed_value, removed_value);
				mismatches++;
			end
			if (found !== e.found) begin
				$error("found: expected %0d, got %0d", e.found, found);
				mismatches++;
			end
			if (error_code !== e.error_code) begin
				$error("error_code: expected %0d, got %0d", e.error_code, error_code);
				mismatches++;
			end
			if (entry_count !== e.entry_count) begin
				$error("entry_count: expected %0d, got %0d", e.entry_count, entry_count);
				mismatches++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_ready;
	op_t operation = OP_INSERT;
	logic signed [DATA_W-1:0] item_value = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	logic signed [DATA_W-1:0] removed_value;
	logic found;
	err_t error_code;
	logic [COUNT_W-1:0] entry_count;

	queue_scoreboard sb = new();
	bit no_idle = 1'b0;
	int hold_requests = 0;
	int items_sent = 0;

	fifo_queue_with_search #(.QUEUE_DEPTH(DEPTH)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.operation(operation),
		.item_value(item_value),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.removed_value(removed_value),
		.found(found),
		.error_code(error_code),
		.entry_count(entry_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Offers one operation, waits for the edge where its transfer happens and at times idles before it returns.
	task automatic send_op(input op_t op, input logic signed [DATA_W-1:0] value);
		item_valid <= 1'b1;
		operation <= op;
		item_value <= value;
		do @(posedge clk); while (!item_ready);
		sb.note_transfer(op, value);
		items_sent++;
		if (!no_idle && $urandom_range(0, 99) < 10) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	function automatic logic signed [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2: return -1;
			3, 4, 5: return $urandom_range(0, 15);
			default: return $urandom;
		endcase
	endfunction

	// When the queue holds items, searches aim at a held value half of the time so that hits are common.
	function automatic logic signed [DATA_W-1:0] pick_search_value();
		if (sb.held > 0 && $urandom_range(0, 1) == 1)
			return sb.mirror_store[(sb.head_pos + $urandom_range(0, sb.held - 1)) % DEPTH];
		return pick_value();
	endfunction

	function automatic op_t pick_op(op_mix_t mix);
		int roll;
		int insert_pct;
		int delete_pct;
		roll = $urandom_range(0, 99);
		case (mix)
			MIX_FILL: begin
				insert_pct = 65;
				delete_pct = 20;
			end
			MIX_DRAIN: begin
				insert_pct = 20;
				delete_pct = 65;
			end
			default: begin
				insert_pct = 40;
				delete_pct = 35;
			end
		endcase
		if (roll < 2)
			return OP_UNUSED;
		if (roll < 2 + insert_pct)
			return OP_INSERT;
		if (roll < 2 + insert_pct + delete_pct)
			return OP_DELETE;
		return OP_SEARCH;
	endfunction

	// Result side: checks each transfer and paces result_ready, including the long hold-off.
	initial begin
		int holds_done;
		int hold_left;
		holds_done = 0;
		hold_left = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (result_valid && result_ready)
				sb.check_result(removed_value, found, error_code, entry_count);
			if (hold_requests != holds_done) begin
				holds_done++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ready <= 1'b0;
			end else if (no_idle) begin
				result_ready <= 1'b1;
			end else begin
				result_ready <= ($urandom_range(0, 99) >= 10);
			end
		end
	end

	initial begin
		int quiet_cycles;
		quiet_cycles = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if ((item_valid && item_ready) || (result_valid && result_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Timed out after %0d cycles without a transfer.", quiet_cycles);
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin
		op_mix_t mix;
		op_t op;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: empty refusals, extreme values, a full queue and pointer wrap.
		send_op(OP_DELETE, 32'sd7);
		send_op(OP_SEARCH, 32'sd0);
		send_op(OP_UNUSED, 32'sh5A5A_A5A5);
		send_op(OP_INSERT, 32'sh7FFF_FFFF);
		send_op(OP_INSERT, 32'sh8000_0000);
		send_op(OP_INSERT, -1);
		send_op(OP_INSERT, 32'sd0);
		send_op(OP_SEARCH, -1);
		send_op(OP_SEARCH, 32'sd12345);
		send_op(OP_SEARCH, 32'sh8000_0000);
		send_op(OP_UNUSED, 32'sd0);
		for (int i = 0; i < DEPTH - 4; i++)
			send_op(OP_INSERT, 32'sd100 + i);
		send_op(OP_INSERT, 32'sd999);
		send_op(OP_SEARCH, 32'sd100 + DEPTH - 5);
		send_op(OP_DELETE, 32'sd0);
		send_op(OP_DELETE, -1);
		send_op(OP_INSERT, 32'sh1234_5678);
		send_op(OP_SEARCH, 32'sh1234_5678);

		mix = MIX_EVEN;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 40 == 0)
				mix = op_mix_t'($urandom_range(0, 2));
			// The receiver stalls for a long while here and the block holds in its done state behind it.
			if (n == 300)
				hold_requests++;
			no_idle = (n >= 500 && n < 700);
			op = pick_op(mix);
			if (op == OP_SEARCH)
				send_op(op, pick_search_value());
			else
				send_op(op, pick_value());
		end
		item_valid <= 1'b0;
		no_idle = 1'b0;

		while (sb.awaited_results.size() != 0)
			@(posedge clk);
		repeat (DEPTH + 10) @(posedge clk);

		$display("Sent %0d operations and checked %0d results, through %0d hold-off stretch.",
			items_sent, sb.results_seen, hold_requests);
		$display("Seen %0d inserts refused when full, %0d refusals on empty, %0d search hits.",
			sb.full_refusals, sb.empty_refusals, sb.search_hits);
		if (sb.mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

### sim.f
+incdir+src
src/fqs_pkg.sv
src/fqs_store.sv
src/fifo_queue_with_search.sv
bench/tb_fifo_queue_with_search.sv
